// ----- sv/khbh_pkg.sv -----
// Shared types and constants for the k-mer hash histogram block.
package khbh_pkg;

   localparam int MAX_BINS    = 1024;
   localparam int COUNT_WIDTH = 32;
   localparam int BIN_AW      = $clog2(MAX_BINS);

   // Configuration register indexes
   localparam logic [2:0] CSR_KMER_LENGTH = 3'd0;
   localparam logic [2:0] CSR_BIN_COUNT   = 3'd1;
   localparam logic [2:0] CSR_HASH_SEED   = 3'd2;
   localparam logic [2:0] CSR_HASH_METHOD = 3'd3;
   localparam logic [2:0] CSR_WY_SECRET_A = 3'd4;
   localparam logic [2:0] CSR_WY_SECRET_B = 3'd5;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic METHOD_MURMUR = 1'b0;
   localparam logic METHOD_WY     = 1'b1;

   localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] MUR_C1  = 64'h87c37b91114253d5;
   localparam logic [63:0] MUR_C2  = 64'h4cf5ad432745937f;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_READ,
      ST_WRITE,
      ST_OUT
   } state_type;

   // Multiplier op request from the sequencer
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] prod;
   } mul_rsp_type;

endpackage

// ----- sv/khbh_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface khbh_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [1:0] base;
   logic [9:0] bin_index;
   modport source (output valid, cmd, base, bin_index, input ready);
   modport sink (input valid, cmd, base, bin_index, output ready);
endinterface

interface khbh_rsp_if;
   logic        valid;
   logic        ready;
   logic        window_full;
   logic [63:0] hash_value;
   logic [9:0]  bucket;
   logic [31:0] bin_value;
   modport source (output valid, window_full, hash_value, bucket, bin_value, input ready);
   modport sink (input valid, window_full, hash_value, bucket, bin_value, output ready);
endinterface

// ----- sv/khbh_mul.sv -----
// Iterative 64x64->128 multiplier: one 32x32 partial product per cycle.
module khbh_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  khbh_pkg::mul_req_type req,
   output khbh_pkg::mul_rsp_type rsp
);
   logic [2:0]   step_ff, step_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  op_a, op_b;
   logic [63:0]  pp;
   logic [127:0] pp_sh;

   // select partial product for this step
   always_comb begin
      op_a  = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      op_b  = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp    = 64'(op_a) * 64'(op_b);
      case (step_ff[1:0])
         2'b00:   pp_sh = {64'd0, pp};
         2'b11:   pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   always_comb begin
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         step_in = 3'd4;
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
      end else if (step_ff != 3'd0) begin
         acc_in  = acc_ff + pp_sh;
         step_in = step_ff - 3'd1;
      end
   end

   // step counts 4..1; its low two bits pick the operand halves
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
      end else begin
         step_ff <= step_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = (step_ff == 3'd0);
   assign rsp.prod = acc_ff;
endmodule

// ----- sv/khbh_hist_ram.sv -----
// Histogram memory: one write port, one registered read port.
module khbh_hist_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [khbh_pkg::BIN_AW-1:0]      wr_addr,
   input  logic [khbh_pkg::COUNT_WIDTH-1:0] wr_data,
   input  logic [khbh_pkg::BIN_AW-1:0]      rd_addr,
   output logic [khbh_pkg::COUNT_WIDTH-1:0] rd_data
);
   logic [khbh_pkg::COUNT_WIDTH-1:0] mem [khbh_pkg::MAX_BINS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- sv/kmer_hash_bucket_histogram_core.sv -----
// Top level of the k-mer hash bucket histogram block.
//
// Channels: req (cmd, base, bin_index) and rsp (window_full, hash_value,
// bucket, bin_value), both valid/ready; a word moves when both are high.
// csr_* is a plain write port: csr_write, csr_index, csr_data.
// Each request yields exactly one response word.
// A bin read goes from accept through the READ and OUT states to rsp
// valid; a push before the window is full goes through OUT alone. A hashed
// push runs the 64x64 multiplies on one shared unit that makes one 32x32
// partial product a cycle: MurmurHash3 needs 6 products, wyhash 3, then a
// 64-step restoring remainder for the bucket and a read-modify-write of the bin.
// The block takes one item at a time; the next request is taken in the
// cycle the response word is loaded, so the item rate equals the latency.
// After reset, a clearing pass writes all MAX_BINS = 1024 bins to zero, one
// per cycle, during which no request is taken.
// The response register holds its word while rsp.ready is low; a request
// is still taken, but its result waits in the last step until that word leaves.
module kmer_hash_bucket_histogram_core (
   input  logic                  clock,
   input  logic                  reset,
   khbh_req_if.sink              req,
   khbh_rsp_if.source            rsp,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_data
);
   localparam int AW = khbh_pkg::BIN_AW;
   localparam int CW = khbh_pkg::COUNT_WIDTH;

   // config registers
   logic [5:0]  klen_ff;
   logic [10:0] nbins_ff;
   logic [31:0] seed_ff;
   logic        method_ff;
   logic [63:0] seca_ff, secb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff   <= 6'd21;
         nbins_ff  <= 11'd1024;
         seed_ff   <= '0;
         method_ff <= khbh_pkg::METHOD_MURMUR;
         seca_ff   <= '0;
         secb_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            khbh_pkg::CSR_KMER_LENGTH: klen_ff   <= csr_data[5:0];
            khbh_pkg::CSR_BIN_COUNT:   nbins_ff  <= csr_data[10:0];
            khbh_pkg::CSR_HASH_SEED:   seed_ff   <= csr_data[31:0];
            khbh_pkg::CSR_HASH_METHOD: method_ff <= csr_data[0];
            khbh_pkg::CSR_WY_SECRET_A: seca_ff   <= csr_data;
            khbh_pkg::CSR_WY_SECRET_B: secb_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   khbh_pkg::state_type state_ff, state_in;
   logic [63:0]  win_ff, win_in;
   logic [5:0]   seen_ff, seen_in;
   logic [AW:0]  clr_ff, clr_in;
   logic [3:0]   op_ff, op_in;      // multiply program step
   logic [63:0]  h1_ff, h1_in, h2_ff, h2_in, t_ff, t_in;
   logic         isread_ff, isread_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [9:0]   rem_ff, rem_in;
   logic [6:0]   dcnt_ff, dcnt_in;
   logic [10:0]  nb_ff, nb_in;
   logic         full_ff, full_in;
   logic         ovalid_ff, ovalid_in;
   logic         ofull_ff, ofull_in;
   logic [63:0]  ohash_ff, ohash_in;
   logic [9:0]   obkt_ff, obkt_in;
   logic [31:0]  obin_ff, obin_in;

   khbh_pkg::mul_req_type mreq;
   khbh_pkg::mul_rsp_type mrsp;
   logic [127:0] prod;
   logic [63:0]  plo, phi;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [CW-1:0] wr_data, rd_data;

   khbh_mul u_mul (.clock, .reset, .req(mreq), .rsp(mrsp));
   khbh_hist_ram u_ram (.clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   assign prod = mrsp.prod;
   assign plo  = prod[63:0];
   assign phi  = prod[127:64];

   function automatic logic [63:0] xs33(input logic [63:0] v);
      xs33 = v ^ (v >> 33);
   endfunction

   // derived values for a push
   logic [5:0]  klen_eff;
   logic [10:0] nb_eff;
   logic [63:0] kmask, key, win_nxt, wy_a;
   logic [5:0]  seen_nxt;
   always_comb begin
      klen_eff = (klen_ff == 6'd0) ? 6'd1 : ((klen_ff > 6'd32) ? 6'd32 : klen_ff);
      nb_eff   = (nbins_ff == 11'd0) ? 11'd1
                 : ((nbins_ff > 11'(khbh_pkg::MAX_BINS)) ? 11'(khbh_pkg::MAX_BINS)
                 : nbins_ff);
      win_nxt  = {win_ff[61:0], req.base};
      seen_nxt = (seen_ff < 6'd32) ? seen_ff + 6'd1 : seen_ff;
      kmask    = (klen_eff == 6'd32) ? '1 : ((64'd1 << {klen_eff, 1'b0}) - 64'd1);
      key      = win_nxt & kmask;
      wy_a     = {key[31:0], key[63:32]} ^ secb_ff;
   end

   // restoring remainder step: shift in the next hash bit, MSB first
   logic [10:0] div_sh;
   always_comb div_sh = {rem_ff, t_ff[dcnt_ff[5:0]]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         khbh_pkg::ST_CLEAR: if (clr_ff == (AW+1)'(khbh_pkg::MAX_BINS - 1))
                                state_in = khbh_pkg::ST_IDLE;
         khbh_pkg::ST_IDLE: if (req.valid && req.ready) begin
               if (req.cmd == khbh_pkg::CMD_READ) state_in = khbh_pkg::ST_READ;
               else if (seen_nxt >= klen_eff) state_in = khbh_pkg::ST_MUL;
               else state_in = khbh_pkg::ST_OUT;
            end
         khbh_pkg::ST_MUL: if (mrsp.done) begin
               if (method_ff == khbh_pkg::METHOD_MURMUR) begin
                  if (op_ff == 4'd0) state_in = khbh_pkg::ST_ADD;
                  else if (op_ff == 4'd5) state_in = khbh_pkg::ST_DIV;
               end else if (op_ff == 4'd2 && t_ff != 64'd0) state_in = khbh_pkg::ST_DIV;
            end
         khbh_pkg::ST_ADD: state_in = khbh_pkg::ST_MUL;
         khbh_pkg::ST_DIV: if (dcnt_ff == 7'd0) state_in = khbh_pkg::ST_READ;
         khbh_pkg::ST_READ: state_in = isread_ff ? khbh_pkg::ST_OUT : khbh_pkg::ST_WRITE;
         khbh_pkg::ST_WRITE: state_in = khbh_pkg::ST_OUT;
         khbh_pkg::ST_OUT: if (!ovalid_ff || rsp.ready) state_in = khbh_pkg::ST_IDLE;
         default: state_in = khbh_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      win_in = win_ff; seen_in = seen_ff; clr_in = clr_ff; op_in = op_ff;
      h1_in = h1_ff; h2_in = h2_ff; t_in = t_ff; isread_in = isread_ff;
      idx_in = idx_ff; rem_in = rem_ff; dcnt_in = dcnt_ff; nb_in = nb_ff;
      full_in = full_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      ofull_in = ofull_ff; ohash_in = ohash_ff; obkt_in = obkt_ff; obin_in = obin_ff;
      mreq = '0;
      wr_en = 1'b0; wr_addr = idx_ff; wr_data = '0; rd_addr = idx_ff;
      case (state_ff)
         khbh_pkg::ST_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
         end
         khbh_pkg::ST_IDLE: if (req.valid && req.ready) begin
               isread_in = (req.cmd == khbh_pkg::CMD_READ);
               idx_in = req.bin_index[AW-1:0];
               full_in = 1'b0; t_in = '0; nb_in = nb_eff;
               if (req.cmd == khbh_pkg::CMD_PUSH) begin
                  win_in = win_nxt; seen_in = seen_nxt;
                  if (seen_nxt >= klen_eff) begin
                     full_in = 1'b1;
                     mreq.start = 1'b1;
                     if (method_ff == khbh_pkg::METHOD_MURMUR) begin
                        mreq.a = key; mreq.b = khbh_pkg::MUR_C1; op_in = 4'd1;
                     end else begin
                        mreq.a = seca_ff; mreq.b = secb_ff; op_in = 4'd1;
                        h1_in = wy_a; h2_in = key;
                     end
                  end
               end
            end
         khbh_pkg::ST_MUL: if (mrsp.done) begin
               if (method_ff == khbh_pkg::METHOD_MURMUR) begin
                  case (op_ff)
                     4'd1: begin // k1 rotated, times C2
                        mreq.start = 1'b1; mreq.a = {plo[32:0], plo[63:33]};
                        mreq.b = khbh_pkg::MUR_C2; op_in = 4'd0;
                     end
                     4'd0: begin // mix into h1/h2
                        h1_in = ({32'd0, seed_ff} ^ plo) ^ 64'd8;
                        h2_in = {32'd0, seed_ff} ^ 64'd8;
                     end
                     4'd2: begin
                        mreq.start = 1'b1; mreq.a = xs33(plo); mreq.b = khbh_pkg::FMIX_C2;
                        op_in = 4'd3;
                     end
                     4'd3: begin
                        h1_in = xs33(plo);
                        mreq.start = 1'b1; mreq.a = xs33(h2_ff); mreq.b = khbh_pkg::FMIX_C1;
                        op_in = 4'd4;
                     end
                     4'd4: begin
                        mreq.start = 1'b1; mreq.a = xs33(plo); mreq.b = khbh_pkg::FMIX_C2;
                        op_in = 4'd5;
                     end
                     4'd5: begin
                        t_in = h1_ff + xs33(plo);
                        rem_in = '0; dcnt_in = 7'd63;
                     end
                     default: ;
                  endcase
               end else begin
                  case (op_ff)
                     4'd1: begin // seed, then main product
                        mreq.start = 1'b1; mreq.a = h1_ff;
                        mreq.b = h2_ff ^ plo ^ phi; op_in = 4'd2;
                     end
                     4'd2: begin
                        if (op_ff == 4'd2 && t_ff == '0) begin
                           mreq.start = 1'b1; mreq.a = plo ^ seca_ff ^ 64'd8;
                           mreq.b = phi ^ secb_ff; t_in = 64'd1; op_in = 4'd2;
                        end else begin
                           t_in = plo ^ phi; rem_in = '0; dcnt_in = 7'd63;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         khbh_pkg::ST_ADD: begin // h1 += h2; h2 += h1; start fmix(h1)
            h1_in = h1_ff + h2_ff;
            h2_in = h2_ff + h1_ff + h2_ff;
            mreq.start = 1'b1; mreq.a = xs33(h1_ff + h2_ff);
            mreq.b = khbh_pkg::FMIX_C1; op_in = 4'd2;
         end
         khbh_pkg::ST_DIV: begin
            rem_in = (div_sh >= nb_ff) ? 10'(div_sh - nb_ff) : div_sh[9:0];
            if (dcnt_ff == 7'd0) begin
               idx_in = rem_in;
            end else begin
               dcnt_in = dcnt_ff - 7'd1;
            end
         end
         khbh_pkg::ST_READ: ;
         khbh_pkg::ST_WRITE: begin
            wr_en = 1'b1;
            wr_data = (rd_data == '1) ? rd_data : rd_data + 1'b1;
         end
         khbh_pkg::ST_OUT: if (!ovalid_ff || rsp.ready) begin
               ovalid_in = 1'b1;
               ofull_in = full_ff;
               ohash_in = full_ff ? t_ff : 64'd0;
               obkt_in = full_ff ? idx_ff : 10'd0;
               obin_in = isread_ff ? 32'(rd_data) : 32'd0;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= khbh_pkg::ST_CLEAR;
         clr_ff <= '0; win_ff <= '0; seen_ff <= '0; ovalid_ff <= 1'b0; op_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in; win_ff <= win_in; seen_ff <= seen_in;
         ovalid_ff <= ovalid_in; op_ff <= op_in;
      end
      h1_ff <= h1_in; h2_ff <= h2_in; t_ff <= t_in; isread_ff <= isread_in;
      idx_ff <= idx_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in; nb_ff <= nb_in;
      full_ff <= full_in; ofull_ff <= ofull_in; ohash_ff <= ohash_in;
      obkt_ff <= obkt_in; obin_ff <= obin_in;
   end

   assign req.ready = (state_ff == khbh_pkg::ST_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.window_full = ofull_ff;
   assign rsp.hash_value = ohash_ff;
   assign rsp.bucket = obkt_ff;
   assign rsp.bin_value = obin_ff;

   a_noreq_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == khbh_pkg::ST_CLEAR |-> !req.ready) else $error("ready in clear");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("rsp dropped");
   a_write_only_rmw: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == khbh_pkg::ST_WRITE || state_ff == khbh_pkg::ST_CLEAR)
      else $error("stray write");
endmodule

// ----- bench/tb_kmer_hash_bucket_histogram_core.sv -----
// Testbench for the k-mer hash bucket histogram core: self-predicting, randomized.
`timescale 1ns / 1ps

module tb_kmer_hash_bucket_histogram_core;

   typedef struct packed {
      logic       cmd;
      logic [1:0] base;
      logic [9:0] bin_index;
   } req_word_type;

   typedef struct packed {
      logic        window_full;
      logic [63:0] hash_value;
      logic [9:0]  bucket;
      logic [31:0] bin_value;
   } rsp_word_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [2:0] csr_index;
   logic [63:0] csr_data;

   khbh_req_if req ();
   khbh_rsp_if rsp ();

   kmer_hash_bucket_histogram_core u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predictor state
   logic [5:0]  cfg_kmer_length;
   logic [10:0] cfg_bin_count;
   logic [31:0] cfg_seed;
   logic        cfg_method;
   logic [63:0] cfg_secret_a;
   logic [63:0] cfg_secret_b;
   logic [63:0] window_bases;
   int unsigned bases_pushed;
   logic [31:0] bin_counts [khbh_pkg::MAX_BINS];

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   int error_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_cycles;
   logic driving;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] fmix64(logic [63:0] v);
      v = v ^ (v >> 33);
      v = v * khbh_pkg::FMIX_C1;
      v = v ^ (v >> 33);
      v = v * khbh_pkg::FMIX_C2;
      v = v ^ (v >> 33);
      return v;
   endfunction

   function automatic logic [63:0] murmur_key(logic [63:0] key, logic [31:0] seed);
      logic [63:0] h1;
      logic [63:0] h2;
      logic [63:0] k1;
      h1 = {32'd0, seed};
      h2 = {32'd0, seed};
      k1 = key * khbh_pkg::MUR_C1;
      k1 = {k1[32:0], k1[63:33]};
      k1 = k1 * khbh_pkg::MUR_C2;
      h1 = h1 ^ k1 ^ 64'd8;
      h2 = h2 ^ 64'd8;
      h1 = h1 + h2;
      h2 = h2 + h1;
      h1 = fmix64(h1);
      h2 = fmix64(h2);
      return h1 + h2;
   endfunction

   function automatic logic [63:0] fold_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[63:0] ^ p[127:64];
   endfunction

   function automatic logic [63:0] wy_key(logic [63:0] key);
      logic [63:0] seed;
      logic [63:0] a;
      logic [63:0] b;
      logic [127:0] p;
      seed = fold_mul(cfg_secret_a, cfg_secret_b);
      a = {key[31:0], key[63:32]} ^ cfg_secret_b;
      b = key ^ seed;
      p = {64'd0, a} * {64'd0, b};
      return fold_mul(p[63:0] ^ cfg_secret_a ^ 64'd8, p[127:64] ^ cfg_secret_b);
   endfunction

   // Work out the response for one accepted request
   function automatic rsp_word_type predict_histogram(req_word_type w);
      rsp_word_type r;
      int unsigned k;
      int unsigned nb;
      logic [63:0] key;
      logic [63:0] h;
      int unsigned bk;
      r = '0;
      if (w.cmd == khbh_pkg::CMD_READ) begin
         r.bin_value = bin_counts[w.bin_index];
         return r;
      end
      window_bases = {window_bases[61:0], w.base};
      if (bases_pushed < 32) bases_pushed++;
      k = 32'(cfg_kmer_length);
      if (k == 0) k = 1;
      if (k > 32) k = 32;
      nb = 32'(cfg_bin_count);
      if (nb == 0) nb = 1;
      if (nb > khbh_pkg::MAX_BINS) nb = khbh_pkg::MAX_BINS;
      if (bases_pushed < k) return r;
      key = (k == 32) ? window_bases : (window_bases & ((64'd1 << (2 * k)) - 64'd1));
      h = (cfg_method == khbh_pkg::METHOD_WY) ? wy_key(key) : murmur_key(key, cfg_seed);
      bk = 32'(h % 64'(nb));
      if (bin_counts[bk] != 32'hffff_ffff) bin_counts[bk]++;
      r.window_full = 1'b1;
      r.hash_value = h;
      r.bucket = bk[9:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic write_csr(logic [2:0] idx, logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         khbh_pkg::CSR_KMER_LENGTH: cfg_kmer_length = value[5:0];
         khbh_pkg::CSR_BIN_COUNT:   cfg_bin_count = value[10:0];
         khbh_pkg::CSR_HASH_SEED:   cfg_seed = value[31:0];
         khbh_pkg::CSR_HASH_METHOD: cfg_method = value[0];
         khbh_pkg::CSR_WY_SECRET_A: cfg_secret_a = value;
         khbh_pkg::CSR_WY_SECRET_B: cfg_secret_b = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Wait until everything queued has been answered
   task automatic drain_words();
      while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_word_type push_word(logic [1:0] b);
      req_word_type w;
      w.cmd = khbh_pkg::CMD_PUSH;
      w.base = b;
      w.bin_index = 10'($urandom);
      return w;
   endfunction

   function automatic req_word_type read_word(logic [9:0] idx);
      req_word_type w;
      w.cmd = khbh_pkg::CMD_READ;
      w.base = 2'($urandom);
      w.bin_index = idx;
      return w;
   endfunction

   // Mostly pushes, some reads; half of the reads go to bins 0 to 7
   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 80) pending_words.push_back(push_word(2'($urandom)));
         else if ($urandom_range(1)) pending_words.push_back(read_word(10'($urandom)));
         else pending_words.push_back(read_word(10'($urandom_range(7))));
      end
   endtask

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            void'(pending_words.pop_front());
            expected_words.push_back(predict_histogram({req.cmd, req.base, req.bin_index}));
         end
         if (!req.valid || req.ready) begin
            if (pending_words.size() != 0 && driving &&
                $urandom_range(99) >= send_idle_pct) begin
               req.valid <= 1'b1;
               {req.cmd, req.base, req.bin_index} <= pending_words[0];
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver hold-off countdown
   always @(posedge clock) begin
      if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
   end

   // Monitor
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp.hash_value, 64'd0);
            end else begin
               want = expected_words.pop_front();
               if (rsp.window_full !== want.window_full)
                  report_mismatch("window_full", 64'(rsp.window_full), 64'(want.window_full));
               if (rsp.hash_value !== want.hash_value)
                  report_mismatch("hash_value", rsp.hash_value, want.hash_value);
               if (rsp.bucket !== want.bucket)
                  report_mismatch("bucket", 64'(rsp.bucket), 64'(want.bucket));
               if (rsp.bin_value !== want.bin_value)
                  report_mismatch("bin_value", 64'(rsp.bin_value), 64'(want.bin_value));
            end
         end
         if (hold_off_cycles > 0) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      error_count = 0;
      send_idle_pct = 36;
      recv_idle_pct = 64;
      hold_off_cycles = 0;
      driving = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = khbh_pkg::CSR_KMER_LENGTH;
      csr_data = '0;
      req.valid = 1'b0;
      req.cmd = khbh_pkg::CMD_PUSH;
      req.base = '0;
      req.bin_index = '0;
      rsp.ready = 1'b0;
      cfg_kmer_length = 6'd21;
      cfg_bin_count = 11'd1024;
      cfg_seed = '0;
      cfg_method = khbh_pkg::METHOD_MURMUR;
      cfg_secret_a = '0;
      cfg_secret_b = '0;
      window_bases = '0;
      bases_pushed = 0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: short k-mer, reset-time seed, every base code, extreme bins
      write_csr(khbh_pkg::CSR_KMER_LENGTH, 64'd2);
      for (int b = 0; b < 4; b++) pending_words.push_back(push_word(2'(b)));
      pending_words.push_back(push_word(2'd3));
      pending_words.push_back(read_word(10'd0));
      pending_words.push_back(read_word(10'd1023));
      driving = 1'b1;
      drain_words();

      // Directed: full length 32, wyhash, small bin count, then out-of-range lengths
      write_csr(khbh_pkg::CSR_KMER_LENGTH, 64'd32);
      write_csr(khbh_pkg::CSR_BIN_COUNT, 64'd1);
      write_csr(khbh_pkg::CSR_HASH_METHOD, {63'd0, khbh_pkg::METHOD_WY});
      write_csr(khbh_pkg::CSR_WY_SECRET_A, 64'hffff_ffff_ffff_ffff);
      write_csr(khbh_pkg::CSR_WY_SECRET_B, 64'ha076_1d64_78bd_642f);
      for (int i = 0; i < 34; i++) pending_words.push_back(push_word(2'($urandom)));
      pending_words.push_back(read_word(10'd0));
      drain_words();
      write_csr(khbh_pkg::CSR_KMER_LENGTH, 64'd0);
      write_csr(khbh_pkg::CSR_BIN_COUNT, 64'd0);
      pending_words.push_back(push_word(2'd2));
      pending_words.push_back(read_word(10'd0));
      drain_words();
      write_csr(khbh_pkg::CSR_KMER_LENGTH, 64'd63);
      write_csr(khbh_pkg::CSR_BIN_COUNT, 64'd2047);
      write_csr(khbh_pkg::CSR_HASH_METHOD, {63'd0, khbh_pkg::METHOD_MURMUR});
      write_csr(khbh_pkg::CSR_HASH_SEED, 64'hffff_ffff);
      pending_words.push_back(push_word(2'd1));
      pending_words.push_back(read_word(10'd1023));
      drain_words();

      // Random phases across settings and idling patterns
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 64;
            recv_idle_pct = 36;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(khbh_pkg::CSR_KMER_LENGTH, 64'($urandom_range(32, 1)));
         write_csr(khbh_pkg::CSR_BIN_COUNT, (phase % 2) ? 64'($urandom_range(8, 1))
                                                        : 64'($urandom_range(1024, 1)));
         write_csr(khbh_pkg::CSR_HASH_SEED, 64'($urandom));
         write_csr(khbh_pkg::CSR_HASH_METHOD, 64'(phase % 2));
         write_csr(khbh_pkg::CSR_WY_SECRET_A, {32'($urandom), 32'($urandom)});
         write_csr(khbh_pkg::CSR_WY_SECRET_B, {32'($urandom), 32'($urandom)});
         if (phase == 4) hold_off_cycles = 400;
         queue_random(190);
         drain_words();
      end

      driving = 1'b0;
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/khbh_pkg.sv
sv/khbh_if.sv
sv/khbh_mul.sv
sv/khbh_hist_ram.sv
sv/kmer_hash_bucket_histogram_core.sv
bench/tb_kmer_hash_bucket_histogram_core.sv
